// ===== src/irst_pkg.sv =====
`default_nettype none

package irst_pkg;

   // field widths of the request and response beats
   localparam int FUNC_W     = 3;
   localparam int SLOT_W     = 4;
   localparam int MASK_W     = 6;
   localparam int CODE_W     = 16;
   localparam int SLOT_OUT_W = 3;

   // configuration register widths and port layout
   localparam int LIMIT_W    = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // switches that count toward the mask population limits
   localparam int SWITCHES = 6;
   localparam int POP_W    = $clog2(SWITCHES + 1);

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_OUTPUTS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_OUTPUTS    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_KEEP_MASK = 2'd2;

   // configuration reset values
   localparam logic [LIMIT_W-1:0] MIN_OUTPUTS_RST    = 3'd2;
   localparam logic [LIMIT_W-1:0] MAX_OUTPUTS_RST    = 3'd6;
   localparam logic [CODE_W-1:0]  CODE_KEEP_MASK_RST = 16'd2047;

   // operation codes
   localparam logic [FUNC_W-1:0] FN_REGISTER   = 3'd0;
   localparam logic [FUNC_W-1:0] FN_UNREGISTER = 3'd1;
   localparam logic [FUNC_W-1:0] FN_EXEC_INDEX = 3'd2;
   localparam logic [FUNC_W-1:0] FN_EXEC_CODE  = 3'd3;
   localparam logic [FUNC_W-1:0] FN_FIND_SLOT  = 3'd4;
   localparam logic [FUNC_W-1:0] FN_READ_ENTRY = 3'd5;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
   } irst_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic scan_last;
      logic out_free;
   } irst_stat_type;

endpackage

`default_nettype wire

// ===== src/irst_if.sv =====
`default_nettype none

// request channel: one operation per beat
interface irst_req_if import irst_pkg::*;;
   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [SLOT_W-1:0]   scene_slot;
   logic [MASK_W-1:0]   sw_mask;
   logic [CODE_W-1:0]   ir_code;

   modport source (output valid, func, scene_slot, sw_mask, ir_code, input ready);
   modport sink   (input valid, func, scene_slot, sw_mask, ir_code, output ready);
endinterface

// response channel: one result per beat
interface irst_rsp_if import irst_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic                  ok;
   logic [SLOT_OUT_W-1:0] slot_out;
   logic [MASK_W-1:0]     mask_out;
   logic [CODE_W-1:0]     code_out;
   logic                  active_out;

   modport source (output valid, ok, slot_out, mask_out, code_out, active_out, input ready);
   modport sink   (input valid, ok, slot_out, mask_out, code_out, active_out, output ready);
endinterface

`default_nettype wire

// ===== src/irst_ctrl.sv =====
`default_nettype none

module irst_ctrl import irst_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire irst_stat_type stat,
   output irst_cmd_type       cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   state_type state_ff;
   logic      ready_ff;

   // command decode
   always_comb begin
      cmd.load   = req_valid && ready_ff;
      cmd.scan   = (state_ff == ST_SCAN);
      cmd.commit = (state_ff == ST_COMMIT) && stat.out_free;
   end

   assign req_ready = ready_ff;

   // sequencer: take a beat, walk every entry, then write back and post the result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid && ready_ff) begin
                  state_ff <= ST_SCAN;
                  ready_ff <= 1'b0;
               end
            end
            ST_SCAN: begin
               if (stat.scan_last) begin
                  state_ff <= ST_COMMIT;
               end
            end
            ST_COMMIT: begin
               if (stat.out_free) begin
                  state_ff <= ST_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               ready_ff <= 1'b1;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== src/irst_dp.sv =====
`default_nettype none

module irst_dp import irst_pkg::*; #(
   parameter int SCENES = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire irst_cmd_type          cmd,
   output irst_stat_type              stat,
   input  wire logic [FUNC_W-1:0]     func,
   input  wire logic [SLOT_W-1:0]     scene_slot,
   input  wire logic [MASK_W-1:0]     sw_mask,
   input  wire logic [CODE_W-1:0]     ir_code,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       ok,
   output logic [SLOT_OUT_W-1:0]      slot_out,
   output logic [MASK_W-1:0]          mask_out,
   output logic [CODE_W-1:0]          code_out,
   output logic                       active_out
);

   localparam int IDX_W = (SCENES > 1) ? $clog2(SCENES) : 1;

   // scene table
   logic [MASK_W-1:0] mask_arr_ff [SCENES];
   logic [CODE_W-1:0] code_arr_ff [SCENES];
   logic [SCENES-1:0] act_arr_ff;

   // configuration
   logic [LIMIT_W-1:0] min_ff;
   logic [LIMIT_W-1:0] max_ff;
   logic [CODE_W-1:0]  keep_ff;

   // current operation
   logic [FUNC_W-1:0] func_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [MASK_W-1:0] mask_ff;
   logic [CODE_W-1:0] clean_ff;
   logic              in_range_ff;
   logic              reg_ok_ff;

   // scan state
   logic [IDX_W-1:0]  cnt_ff;
   logic              hit_ff;
   logic [IDX_W-1:0]  hit_slot_ff;
   logic [MASK_W-1:0] hit_mask_ff;
   logic              free_ff;
   logic [IDX_W-1:0]  free_slot_ff;

   // response register
   logic                  rsp_valid_ff;
   logic                  ok_ff;
   logic [SLOT_OUT_W-1:0] slot_out_ff;
   logic [MASK_W-1:0]     mask_out_ff;
   logic [CODE_W-1:0]     code_out_ff;
   logic                  active_out_ff;

   logic [POP_W-1:0]      pop_in;
   logic                  in_range_in;
   logic                  reg_ok_in;
   logic [IDX_W-1:0]      slot_idx;
   logic [IDX_W-1:0]      rd_idx;
   logic [MASK_W-1:0]     rd_mask;
   logic [CODE_W-1:0]     rd_code;
   logic                  rd_act;
   logic                  clean_nz;
   logic                  code_eq;
   logic                  wipe_hit;
   logic                  match;
   logic                  wr_en;
   logic [MASK_W-1:0]     wr_mask;
   logic [CODE_W-1:0]     wr_code;
   logic                  wr_act;
   logic                  ok_in;
   logic [IDX_W-1:0]      res_idx;
   logic [IDX_W+2:0]      res_idx_wide;
   logic [MASK_W-1:0]     mask_out_in;
   logic [CODE_W-1:0]     code_out_in;
   logic                  active_out_in;

   // set bits of the incoming mask among the counted switches
   always_comb begin
      pop_in = '0;
      for (int b = 0; b < SWITCHES && b < MASK_W; b++) begin
         pop_in = pop_in + POP_W'(sw_mask[b]);
      end
   end

   // range and limit checks on the incoming beat
   always_comb begin
      in_range_in = ({1'b0, scene_slot} < (SLOT_W + 1)'(SCENES));
      reg_ok_in   = in_range_in
                    && ((POP_W + LIMIT_W)'(pop_in) >= (POP_W + LIMIT_W)'(min_ff))
                    && ((POP_W + LIMIT_W)'(pop_in) <= (POP_W + LIMIT_W)'(max_ff));
   end

   // single table read port: scan counter while scanning, else the requested slot
   always_comb begin
      slot_idx = slot_ff[IDX_W-1:0];
      rd_idx   = cmd.scan ? cnt_ff : slot_idx;
      rd_mask  = mask_arr_ff[rd_idx];
      rd_code  = code_arr_ff[rd_idx];
      rd_act   = act_arr_ff[rd_idx];
      clean_nz = |clean_ff;
      code_eq  = (rd_code == clean_ff);
   end

   // per-entry scan decisions
   always_comb begin
      wipe_hit = cmd.scan && (func_ff == FN_REGISTER) && reg_ok_ff && clean_nz
                 && (rd_idx != slot_idx) && code_eq;
      match    = ((func_ff == FN_EXEC_CODE) && clean_nz && rd_act && code_eq)
                 || ((func_ff == FN_FIND_SLOT) && rd_act && (rd_mask == mask_ff));
   end

   // table write port: duplicate-code wipe during scan, store or clear on commit
   always_comb begin
      wr_en   = 1'b0;
      wr_mask = '0;
      wr_code = '0;
      wr_act  = 1'b0;
      if (wipe_hit) begin
         wr_en = 1'b1;
      end
      if (cmd.commit) begin
         if ((func_ff == FN_REGISTER) && reg_ok_ff) begin
            wr_en   = 1'b1;
            wr_mask = mask_ff;
            wr_code = clean_ff;
            wr_act  = clean_nz;
         end else if ((func_ff == FN_UNREGISTER) && in_range_ff) begin
            wr_en = 1'b1;
         end
      end
   end

   // result of the operation
   always_comb begin
      ok_in         = 1'b0;
      res_idx       = '0;
      mask_out_in   = '0;
      code_out_in   = '0;
      active_out_in = 1'b0;
      case (func_ff)
         FN_REGISTER: begin
            ok_in = reg_ok_ff;
         end
         FN_UNREGISTER: begin
            ok_in = in_range_ff;
         end
         FN_EXEC_INDEX: begin
            if (in_range_ff && rd_act) begin
               ok_in       = 1'b1;
               mask_out_in = rd_mask;
            end
         end
         FN_EXEC_CODE: begin
            if (hit_ff) begin
               ok_in       = 1'b1;
               res_idx     = hit_slot_ff;
               mask_out_in = hit_mask_ff;
            end
         end
         FN_FIND_SLOT: begin
            ok_in = 1'b1;
            if (hit_ff) begin
               res_idx = hit_slot_ff;
            end else if (free_ff) begin
               res_idx = free_slot_ff;
            end
         end
         FN_READ_ENTRY: begin
            if (in_range_ff) begin
               ok_in         = 1'b1;
               mask_out_in   = rd_mask;
               code_out_in   = rd_code;
               active_out_in = rd_act;
            end
         end
         default: begin
            ok_in = 1'b0;
         end
      endcase
      res_idx_wide = {3'b000, res_idx};
   end

   // status to the controller
   always_comb begin
      stat.scan_last = (cnt_ff == IDX_W'(SCENES - 1));
      stat.out_free  = !rsp_valid_ff || rsp_ready;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff  <= MIN_OUTPUTS_RST;
         max_ff  <= MAX_OUTPUTS_RST;
         keep_ff <= CODE_KEEP_MASK_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MIN_OUTPUTS:    min_ff  <= csr_wdata[LIMIT_W-1:0];
            CSR_MAX_OUTPUTS:    max_ff  <= csr_wdata[LIMIT_W-1:0];
            CSR_CODE_KEEP_MASK: keep_ff <= csr_wdata[CODE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // scene table storage, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SCENES; k++) begin
            mask_arr_ff[k] <= '0;
            code_arr_ff[k] <= '0;
         end
         act_arr_ff <= '0;
      end else if (wr_en) begin
         mask_arr_ff[rd_idx] <= wr_mask;
         code_arr_ff[rd_idx] <= wr_code;
         act_arr_ff[rd_idx]  <= wr_act;
      end
   end

   // capture the operation, toggle bit stripped
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff     <= func;
         slot_ff     <= scene_slot;
         mask_ff     <= sw_mask;
         clean_ff    <= ir_code & keep_ff;
         in_range_ff <= in_range_in;
         reg_ok_ff   <= reg_ok_in;
      end
   end

   // scan counter and first-match trackers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         hit_ff       <= 1'b0;
         hit_slot_ff  <= '0;
         hit_mask_ff  <= '0;
         free_ff      <= 1'b0;
         free_slot_ff <= '0;
      end else if (cmd.load) begin
         cnt_ff       <= '0;
         hit_ff       <= 1'b0;
         hit_slot_ff  <= '0;
         hit_mask_ff  <= '0;
         free_ff      <= 1'b0;
         free_slot_ff <= '0;
      end else if (cmd.scan) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (!hit_ff && match) begin
            hit_ff      <= 1'b1;
            hit_slot_ff <= cnt_ff;
            hit_mask_ff <= rd_mask;
         end
         if (!free_ff && !rd_act) begin
            free_ff      <= 1'b1;
            free_slot_ff <= cnt_ff;
         end
      end
   end

   // response beat
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         ok_ff         <= ok_in;
         slot_out_ff   <= res_idx_wide[SLOT_OUT_W-1:0];
         mask_out_ff   <= mask_out_in;
         code_out_ff   <= code_out_in;
         active_out_ff <= active_out_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign ok         = ok_ff;
   assign slot_out   = slot_out_ff;
   assign mask_out   = mask_out_ff;
   assign code_out   = code_out_ff;
   assign active_out = active_out_ff;

endmodule

`default_nettype wire

// ===== src/ir_scene_table.sv =====
// Scene table for a remote-controlled switch panel. Each of SCENES entries holds a switch
// mask, a remote code with its toggle bit stripped (code AND code_keep_mask) and an active
// mark; reset clears the whole table at once, no clearing pass. One request beat carries one
// operation (register, unregister, execute by index, execute by code, find slot, read entry)
// and gives exactly one response beat. Operations run one at a time: after a request is
// taken, the controller walks the table through its single read port, one entry per cycle,
// then writes back and loads the response register once that register is free. Ready
// returns in the same cycle as the response appears, so a new request is taken only after
// the current operation has written back its result and posted its response.
// A posted response may wait in its register while the next request is already being
// scanned; that request's write-back then waits until the earlier response is taken.
// Configuration writes are taken at any time but are meant to happen only while idle.
`default_nettype none

module ir_scene_table import irst_pkg::*; #(
   parameter int SCENES = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   irst_req_if.sink                   req_chan,
   irst_rsp_if.source                 rsp_chan,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   irst_cmd_type  cmd;
   irst_stat_type stat;
   logic          req_ready;

   // sequencer
   irst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   assign req_chan.ready = req_ready;

   // table, configuration and response register
   irst_dp #(
      .SCENES (SCENES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .func        (req_chan.func),
      .scene_slot  (req_chan.scene_slot),
      .sw_mask     (req_chan.sw_mask),
      .ir_code     (req_chan.ir_code),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .ok          (rsp_chan.ok),
      .slot_out    (rsp_chan.slot_out),
      .mask_out    (rsp_chan.mask_out),
      .code_out    (rsp_chan.code_out),
      .active_out  (rsp_chan.active_out)
   );

endmodule

`default_nettype wire

// ===== src/irst_checker.sv =====
`default_nettype none

module irst_checker import irst_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_ready,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic                  ok,
   input wire logic [SLOT_OUT_W-1:0] slot_out,
   input wire logic [MASK_W-1:0]     mask_out,
   input wire logic [CODE_W-1:0]     code_out,
   input wire logic                  active_out
);

   // a stalled response beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(ok) && $stable(slot_out)
         && $stable(mask_out) && $stable(code_out) && $stable(active_out))
      else $error("response payload changed while stalled");

   // one operation at a time: ready drops after each accepted beat
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an operation is in progress");

   // no response beat comes out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a failed operation reports nothing else
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !ok |-> slot_out == '0 && mask_out == '0 && code_out == '0
         && !active_out)
      else $error("failed operation carries data");

endmodule

bind ir_scene_table irst_checker u_irst_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .ok         (rsp_chan.ok),
   .slot_out   (rsp_chan.slot_out),
   .mask_out   (rsp_chan.mask_out),
   .code_out   (rsp_chan.code_out),
   .active_out (rsp_chan.active_out)
);

`default_nettype wire
